// File: rtl/mtp_pkg.sv
// shared types and constants for the moment tensor polarization core
// no dependencies; imported by mtp_normalize, moment_tensor_polarization_core and the testbench
`default_nettype none
package mtp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_SOURCE_X    = 3'd0;
    localparam logic [2:0] CFG_SOURCE_Y    = 3'd1;
    localparam logic [2:0] CFG_SOURCE_Z    = 3'd2;
    localparam logic [2:0] CFG_MOMENT_ROW0 = 3'd3;
    localparam logic [2:0] CFG_MOMENT_ROW1 = 3'd4;
    localparam logic [2:0] CFG_MOMENT_ROW2 = 3'd5;

    // back end pipeline depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 16;

    localparam logic [15:0] POL_MAX = 16'd32768;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_SAME_POINT  = 2'd1,
        STATUS_ZERO_RESULT = 2'd2
    } status_t;

    // scaled radiation magnitudes and their sum of squares
    typedef struct packed {
        status_t          status;
        logic [2:0][30:0] a;
        logic [63:0]      sum;
    } norm_in_t;

    typedef struct packed {
        status_t          status;
        logic [2:0][15:0] pol;
    } norm_out_t;

endpackage
`default_nettype wire

// File: rtl/mtp_normalize.sv
// normalizing back end: pipelined integer square root and rounded divide
// depends on mtp_pkg
`default_nettype none
module mtp_normalize import mtp_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_vld,
    input  wire norm_in_t  in_word,
    output logic           out_vld,
    output norm_out_t      out_word
);

    logic [63:0]      sv_reg  [1:SQRT_STAGES];
    logic [63:0]      sr_reg  [1:SQRT_STAGES];
    logic [2:0][30:0] sa_reg  [1:SQRT_STAGES];
    status_t          sst_reg [1:SQRT_STAGES];
    logic             svld_reg[1:SQRT_STAGES];

    logic [2:0][46:0] dr_reg  [1:DIV_STAGES];
    logic [2:0][15:0] dq_reg  [1:DIV_STAGES];
    logic [31:0]      dn_reg  [1:DIV_STAGES];
    status_t          dst_reg [1:DIV_STAGES];
    logic             dvld_reg[1:DIV_STAGES];

    norm_out_t out_reg;
    norm_out_t out_next;
    logic      vld_out_reg;

    // one result bit of the root per stage
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        logic [63:0]      v_cur;
        logic [63:0]      r_cur;
        logic [63:0]      bit_w;
        logic [63:0]      trial;
        logic [2:0][30:0] a_cur;
        status_t          st_cur;
        logic             vld_cur;

        if (k == 0) begin : g_first
            assign v_cur   = in_word.sum;
            assign r_cur   = '0;
            assign a_cur   = in_word.a;
            assign st_cur  = in_word.status;
            assign vld_cur = in_vld;
        end else begin : g_rest
            assign v_cur   = sv_reg[k];
            assign r_cur   = sr_reg[k];
            assign a_cur   = sa_reg[k];
            assign st_cur  = sst_reg[k];
            assign vld_cur = svld_reg[k];
        end

        assign bit_w = 64'd1 << (62 - 2 * k);
        assign trial = r_cur + bit_w;

        always_ff @(posedge clk)
        begin
            if (v_cur >= trial)
            begin
                sv_reg[k+1] <= v_cur - trial;
                sr_reg[k+1] <= (r_cur >> 1) + bit_w;
            end
            else
            begin
                sv_reg[k+1] <= v_cur;
                sr_reg[k+1] <= r_cur >> 1;
            end
            sa_reg[k+1]  <= a_cur;
            sst_reg[k+1] <= st_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                svld_reg[k+1] <= 1'b0;
            else
                svld_reg[k+1] <= vld_cur;
        end
    end

    // restoring divide, one quotient bit per stage on all three lanes
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [2:0][46:0] rem_cur;
        logic [2:0][46:0] rem_nxt;
        logic [2:0][15:0] q_cur;
        logic [2:0][15:0] q_nxt;
        logic [31:0]      n_cur;
        logic [46:0]      div_w;
        status_t          st_cur;
        logic             vld_cur;

        if (k == 0) begin : g_first
            logic [31:0] n_root;
            assign n_root = sr_reg[SQRT_STAGES][31:0];
            // rounding: numerator is a * 2^15 + floor(n / 2)
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_cur[i] = {1'b0, sa_reg[SQRT_STAGES][i], 15'b0}
                                  + {16'b0, n_root[31:1]};
            end
            assign q_cur   = '0;
            assign n_cur   = n_root;
            assign st_cur  = sst_reg[SQRT_STAGES];
            assign vld_cur = svld_reg[SQRT_STAGES];
        end else begin : g_rest
            assign rem_cur = dr_reg[k];
            assign q_cur   = dq_reg[k];
            assign n_cur   = dn_reg[k];
            assign st_cur  = dst_reg[k];
            assign vld_cur = dvld_reg[k];
        end

        assign div_w = {15'b0, n_cur} << (DIV_STAGES - 1 - k);

        always_comb
        begin
            rem_nxt = rem_cur;
            q_nxt   = q_cur;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_cur[i] >= div_w)
                begin
                    rem_nxt[i] = rem_cur[i] - div_w;
                    q_nxt[i][DIV_STAGES-1-k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dr_reg[k+1]  <= rem_nxt;
            dq_reg[k+1]  <= q_nxt;
            dn_reg[k+1]  <= n_cur;
            dst_reg[k+1] <= st_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvld_reg[k+1] <= 1'b0;
            else
                dvld_reg[k+1] <= vld_cur;
        end
    end

    always_comb
    begin
        out_next.status = dst_reg[DIV_STAGES];
        for (int i = 0; i < 3; i++)
        begin
            if (dst_reg[DIV_STAGES] != STATUS_OK)
                out_next.pol[i] = '0;
            else if (dq_reg[DIV_STAGES][i] > POL_MAX)
                out_next.pol[i] = POL_MAX;
            else
                out_next.pol[i] = dq_reg[DIV_STAGES][i];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else
            vld_out_reg <= dvld_reg[DIV_STAGES];
    end

    assign out_vld  = vld_out_reg;
    assign out_word = out_reg;

endmodule
`default_nettype wire

// File: rtl/moment_tensor_polarization_core.sv
// top level of the moment tensor far-field polarization core
// depends on mtp_pkg and mtp_normalize
//
// One target point enters per clock: busy is always low, so a word is taken on every cycle
// that start is high. Each word gives one result, shown with done for a single cycle once it has
// passed 15 front end stages for direction, tensor products and scaling, 32 square root
// stages, 16 divide stages and the output register; results keep their input order and
// must be taken when shown. Configuration writes are always ready and take effect at once;
// write them only while no point is in flight.
`default_nettype none
module moment_tensor_polarization_core import mtp_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] target_z,
    input  wire logic               mode,
    output logic                    done,
    output logic [15:0]             pol_x,
    output logic [15:0]             pol_y,
    output logic [15:0]             pol_z,
    output logic [1:0]              status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data
);

    logic [2:0][31:0] src_reg;
    logic [2:0][47:0] row_reg;

    logic [31:0]        tgt [3];
    logic signed [15:0] tm  [3][3];
    logic               accept;
    logic [15:1]        vld_reg;

    // stage registers and their next values
    logic signed [32:0] d_next     [3], d_reg     [3];
    logic [32:0]        mag2_next  [3], mag2_reg  [3], mag3_reg [3];
    logic [2:0]         neg2_reg, neg3_reg;
    logic [4:0]         sh3_next, sh3_reg;
    logic signed [13:0] e4_next    [3], e4_reg    [3], e5_reg [3], e6_reg [3];
    logic signed [13:0] e7_reg     [3], e8_reg    [3], e9_reg [3];
    logic signed [29:0] p5_next    [3][3], p5_reg [3][3];
    logic [26:0]        sq5_next   [3], sq5_reg   [3];
    logic signed [31:0] mt6_next   [3], mt6_reg   [3];
    logic [27:0]        l26_next, l26_reg;
    logic signed [45:0] qt7_next   [3], qt7_reg   [3];
    logic signed [60:0] ml7_next   [3], ml7_reg   [3], ml8_reg [3], ml9_reg [3];
    logic signed [47:0] q8_next, q8_reg;
    logic signed [37:0] eql9_next  [3], eql9_reg  [3];
    logic signed [38:0] eqh9_next  [3], eqh9_reg  [3];
    logic               qpos9_reg, qneg9_reg;
    logic signed [63:0] r10_next   [3], r10_reg   [3];
    logic [63:0]        mag11_next [3], mag11_reg [3], mag12_reg [3];
    logic [5:0]         t12_next, t12_reg;
    logic [2:0][30:0]   a13_next, a13_reg, a14_reg, a15_reg;
    logic [61:0]        sqa14_next [3], sqa14_reg [3];
    logic [63:0]        sum15_next, sum15_reg;
    logic [9:1]         mode_reg;
    status_t            st3_next, st12_next;
    status_t            st3_reg, st4_reg, st5_reg, st6_reg, st7_reg, st8_reg, st9_reg;
    status_t            st10_reg, st11_reg, st12_reg, st13_reg, st14_reg, st15_reg;

    norm_in_t  nin;
    norm_out_t nout;
    logic      nout_vld;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign tgt[0] = target_x;
    assign tgt[1] = target_y;
    assign tgt[2] = target_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SOURCE_X:    src_reg[0] <= cfg_data[31:0];
                CFG_SOURCE_Y:    src_reg[1] <= cfg_data[31:0];
                CFG_SOURCE_Z:    src_reg[2] <= cfg_data[31:0];
                CFG_MOMENT_ROW0: row_reg[0] <= cfg_data;
                CFG_MOMENT_ROW1: row_reg[1] <= cfg_data;
                CFG_MOMENT_ROW2: row_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                tm[i][j] = $signed(row_reg[i][16*j +: 16]);
    end

    always_comb
    begin
        logic [32:0]        or3;
        logic [5:0]         msb3;
        logic [32:0]        shv;
        logic signed [27:0] sqf;
        logic signed [63:0] eqv;
        logic [63:0]        or12;
        logic [6:0]         msb12;

        for (int i = 0; i < 3; i++)
            d_next[i] = $signed({tgt[i][31], tgt[i]}) - $signed({src_reg[i][31], src_reg[i]});

        for (int i = 0; i < 3; i++)
            mag2_next[i] = d_reg[i][32] ? -d_reg[i] : d_reg[i];

        // block shift so the largest offset fits in 13 bits
        or3  = mag2_reg[0] | mag2_reg[1] | mag2_reg[2];
        msb3 = '0;
        for (int k = 0; k < 33; k++)
            if (or3[k])
                msb3 = 6'(k);
        sh3_next = (msb3 >= 6'd13) ? 5'(msb3 - 6'd12) : 5'd0;
        st3_next = (or3 == '0) ? STATUS_SAME_POINT : STATUS_OK;

        for (int i = 0; i < 3; i++)
        begin
            shv = mag3_reg[i] >> sh3_reg;
            e4_next[i] = neg3_reg[i] ? -$signed({1'b0, shv[12:0]})
                                     : $signed({1'b0, shv[12:0]});
        end

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                p5_next[i][j] = e4_reg[i] * tm[i][j];
            sqf = e4_reg[i] * e4_reg[i];
            sq5_next[i] = sqf[26:0];
        end

        // column sums give M^T e
        for (int j = 0; j < 3; j++)
            mt6_next[j] = 32'(p5_reg[0][j]) + 32'(p5_reg[1][j]) + 32'(p5_reg[2][j]);
        l26_next = 28'(sq5_reg[0]) + 28'(sq5_reg[1]) + 28'(sq5_reg[2]);

        for (int j = 0; j < 3; j++)
        begin
            qt7_next[j] = e6_reg[j] * mt6_reg[j];
            ml7_next[j] = mt6_reg[j] * $signed({1'b0, l26_reg});
        end

        q8_next = 48'(qt7_reg[0]) + 48'(qt7_reg[1]) + 48'(qt7_reg[2]);

        // e * q split into two partial products on the low 23 and high 25 bits of q
        for (int i = 0; i < 3; i++)
        begin
            eql9_next[i] = e8_reg[i] * $signed({1'b0, q8_reg[22:0]});
            eqh9_next[i] = e8_reg[i] * $signed(q8_reg[47:23]);
        end

        for (int i = 0; i < 3; i++)
        begin
            eqv = (64'(eqh9_reg[i]) <<< 23) + 64'(eql9_reg[i]);
            if (mode_reg[9])
                r10_next[i] = 64'(ml9_reg[i]) - eqv;
            else if (qpos9_reg)
                r10_next[i] = 64'(e9_reg[i]);
            else if (qneg9_reg)
                r10_next[i] = -64'(e9_reg[i]);
            else
                r10_next[i] = '0;
        end

        for (int i = 0; i < 3; i++)
            mag11_next[i] = r10_reg[i][63] ? -r10_reg[i] : r10_reg[i];

        // block shift so the largest component fits in 31 bits
        or12  = mag11_reg[0] | mag11_reg[1] | mag11_reg[2];
        msb12 = '0;
        for (int k = 0; k < 64; k++)
            if (or12[k])
                msb12 = 7'(k);
        t12_next  = (msb12 >= 7'd31) ? 6'(msb12 - 7'd30) : 6'd0;
        st12_next = (st11_reg == STATUS_OK && or12 == '0) ? STATUS_ZERO_RESULT : st11_reg;

        for (int i = 0; i < 3; i++)
        begin
            a13_next[i]   = 31'(mag12_reg[i] >> t12_reg);
            sqa14_next[i] = a13_reg[i] * a13_reg[i];
        end

        sum15_next = 64'(sqa14_reg[0]) + 64'(sqa14_reg[1]) + 64'(sqa14_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        mode_reg[1] <= mode;

        mag2_reg    <= mag2_next;
        for (int i = 0; i < 3; i++)
            neg2_reg[i] <= d_reg[i][32];
        mode_reg[2] <= mode_reg[1];

        mag3_reg    <= mag2_reg;
        neg3_reg    <= neg2_reg;
        sh3_reg     <= sh3_next;
        st3_reg     <= st3_next;
        mode_reg[3] <= mode_reg[2];

        e4_reg      <= e4_next;
        st4_reg     <= st3_reg;
        mode_reg[4] <= mode_reg[3];

        p5_reg      <= p5_next;
        sq5_reg     <= sq5_next;
        e5_reg      <= e4_reg;
        st5_reg     <= st4_reg;
        mode_reg[5] <= mode_reg[4];

        mt6_reg     <= mt6_next;
        l26_reg     <= l26_next;
        e6_reg      <= e5_reg;
        st6_reg     <= st5_reg;
        mode_reg[6] <= mode_reg[5];

        qt7_reg     <= qt7_next;
        ml7_reg     <= ml7_next;
        e7_reg      <= e6_reg;
        st7_reg     <= st6_reg;
        mode_reg[7] <= mode_reg[6];

        q8_reg      <= q8_next;
        ml8_reg     <= ml7_reg;
        e8_reg      <= e7_reg;
        st8_reg     <= st7_reg;
        mode_reg[8] <= mode_reg[7];

        eql9_reg    <= eql9_next;
        eqh9_reg    <= eqh9_next;
        qpos9_reg   <= !q8_reg[47] && (q8_reg != '0);
        qneg9_reg   <= q8_reg[47];
        ml9_reg     <= ml8_reg;
        e9_reg      <= e8_reg;
        st9_reg     <= st8_reg;
        mode_reg[9] <= mode_reg[8];

        r10_reg     <= r10_next;
        st10_reg    <= st9_reg;

        mag11_reg   <= mag11_next;
        st11_reg    <= st10_reg;

        mag12_reg   <= mag11_reg;
        t12_reg     <= t12_next;
        st12_reg    <= st12_next;

        a13_reg     <= a13_next;
        st13_reg    <= st12_reg;

        sqa14_reg   <= sqa14_next;
        a14_reg     <= a13_reg;
        st14_reg    <= st13_reg;

        sum15_reg   <= sum15_next;
        a15_reg     <= a14_reg;
        st15_reg    <= st14_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[14:1], accept};
    end

    assign nin.status = st15_reg;
    assign nin.a      = a15_reg;
    assign nin.sum    = sum15_reg;

    mtp_normalize u_normalize (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[15]),
        .in_word  (nin),
        .out_vld  (nout_vld),
        .out_word (nout)
    );

    assign done   = nout_vld;
    assign pol_x  = nout.pol[0];
    assign pol_y  = nout.pol[1];
    assign pol_z  = nout.pol[2];
    assign status = nout.status;

endmodule
`default_nettype wire

// File: verif/tb_moment_tensor_polarization_core.sv
// testbench for moment_tensor_polarization_core: directed and random target points
// checked against a bit-exact predictor through a small scoreboard class; needs mtp_pkg
`default_nettype none
module tb_moment_tensor_polarization_core;
    import mtp_pkg::*;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        status_t     st;
    } pol_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               mode;
    logic               done;
    logic [15:0]        pol_x;
    logic [15:0]        pol_y;
    logic [15:0]        pol_z;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [47:0]        cfg_data;

    int errors = 0;

    // predictor copy of the registers
    logic signed [31:0] src_pos [3];
    logic [47:0]        moment_rows [3];

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint tensor_entry(input int i, input int j);
        logic signed [15:0] v;
        v = moment_rows[i][16*j +: 16];
        return longint'(v);
    endfunction

    function automatic longint absval(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic pol_word_t predict_polarization(input logic signed [31:0] tx,
                                                       input logic signed [31:0] ty,
                                                       input logic signed [31:0] tz,
                                                       input logic md);
        pol_word_t w;
        longint d [3];
        longint e [3];
        longint r [3];
        longint unsigned a [3];
        longint unsigned m, u, sum, n, p;
        longint l2, q, mt;
        int s, t;
        w.px = 0; w.py = 0; w.pz = 0; w.st = STATUS_OK;
        d[0] = longint'(tx) - longint'(src_pos[0]);
        d[1] = longint'(ty) - longint'(src_pos[1]);
        d[2] = longint'(tz) - longint'(src_pos[2]);
        m = 0;
        for (int i = 0; i < 3; i++)
            if (absval(d[i]) > m) m = absval(d[i]);
        if (m == 0)
        begin
            w.st = STATUS_SAME_POINT;
            return w;
        end
        s = 0;
        while ((m >> s) >= (64'd1 << 13)) s++;
        l2 = 0; q = 0;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = longint'(absval(d[i]) >> s);
            if (d[i] < 0) e[i] = -e[i];
            l2 += e[i] * e[i];
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                q += e[i] * tensor_entry(i, j) * e[j];
        u = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (!md)
                r[i] = q > 0 ? e[i] : (q < 0 ? -e[i] : 0);
            else
            begin
                mt = 0;
                for (int j = 0; j < 3; j++) mt += tensor_entry(j, i) * e[j];
                r[i] = mt * l2 - e[i] * q;
            end
            if (absval(r[i]) > u) u = absval(r[i]);
        end
        if (u == 0)
        begin
            w.st = STATUS_ZERO_RESULT;
            return w;
        end
        t = 0;
        while ((u >> t) >= (64'd1 << 31)) t++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = absval(r[i]) >> t;
            sum += a[i] * a[i];
        end
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            p = ((a[i] << 15) + n / 2) / n;
            if (p > 32768) p = 32768;
            if (i == 0) w.px = p[15:0];
            else if (i == 1) w.py = p[15:0];
            else w.pz = p[15:0];
        end
        return w;
    endfunction

    class pol_scoreboard;
        pol_word_t pending[$];

        function void note_point(input logic signed [31:0] tx, input logic signed [31:0] ty,
                                 input logic signed [31:0] tz, input logic md);
            pending.insert(pending.size(), predict_polarization(tx, ty, tz, md));
        endfunction

        task check_result(input logic [15:0] px, input logic [15:0] py,
                          input logic [15:0] pz, input logic [1:0] st);
            pol_word_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (px !== w.px) report("pol_x", px, w.px);
            if (py !== w.py) report("pol_y", py, w.py);
            if (pz !== w.pz) report("pol_z", pz, w.pz);
            if (st !== w.st) report("status", st, w.st);
        endtask
    endclass

    pol_scoreboard board;

    moment_tensor_polarization_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .target_x(target_x), .target_y(target_y), .target_z(target_z), .mode(mode),
        .done(done), .pol_x(pol_x), .pol_y(pol_y), .pol_z(pol_z), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && done)
            board.check_result(pol_x, pol_y, pol_z, status);

    // valid is driven low between writes, which keeps it from being driven twice in one step
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx < CFG_MOMENT_ROW0)
            src_pos[idx] = value[31:0];
        else
            moment_rows[idx - CFG_MOMENT_ROW0] = value;
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    int burst_left = 0;

    // one point word; start stays high across a burst
    task automatic send_point(input logic signed [31:0] tx, input logic signed [31:0] ty,
                              input logic signed [31:0] tz, input logic md);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start    <= 1;
        target_x <= tx;
        target_y <= ty;
        target_z <= tz;
        mode     <= md;
        do @(posedge clk); while (busy);
        board.note_point(tx, ty, tz, md);
        burst_left--;
    endtask

    task automatic drain();
        start <= 0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 4095) - 2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] rand_row();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) v[15:0] = 16'h8000;
        if ($urandom_range(0, 3) == 0) v[31:16] = 16'h7FFF;
        if ($urandom_range(0, 4) == 0) v[47:32] = '0;
        return v;
    endfunction

    initial
    begin
        board = new();
        for (int i = 0; i < 3; i++)
        begin
            src_pos[i] = 0;
            moment_rows[i] = 0;
        end
        rst_n = 0; start = 0; target_x = 0; target_y = 0; target_z = 0; mode = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero tensor after reset: zero result, and the origin is the same point
        send_point(0, 0, 0, 0);
        send_point(32'h0001_0000, 0, 0, 0);
        send_point(0, 32'h0001_0000, 0, 1);
        drain();

        // isotropic tensor with extreme source
        write_reg(CFG_SOURCE_X, 48'h0000_8000_0000);
        write_reg(CFG_SOURCE_Y, 48'h0000_7FFF_FFFF);
        write_reg(CFG_SOURCE_Z, 0);
        write_reg(CFG_MOMENT_ROW0, 48'h0000_0000_4000);
        write_reg(CFG_MOMENT_ROW1, 48'h0000_4000_0000);
        write_reg(CFG_MOMENT_ROW2, 48'h4000_0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1);
        send_point(0, 0, 32'h0000_0001, 1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        drain();

        // tensor with extreme off-diagonal entries, source at origin
        write_reg(CFG_SOURCE_X, 0);
        write_reg(CFG_SOURCE_Y, 0);
        write_reg(CFG_MOMENT_ROW0, 48'h0000_7FFF_0000);
        write_reg(CFG_MOMENT_ROW1, 48'h0000_0000_8000);
        write_reg(CFG_MOMENT_ROW2, 48'hFFFF_0000_0000);
        send_point(32'h0001_0000, 0, 0, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0, 1);
        send_point(0, 0, 32'h7FFF_FFFF, 1);
        send_point(0, 0, 32'h8000_0000, 0);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0, 1);
        send_point(32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 1);
        drain();

        // random phases, each with a fresh configuration
        for (int ph = 0; ph < 10; ph++)
        begin
            logic [31:0] sx, sy, sz;
            sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
            write_reg(CFG_SOURCE_X, {16'h0, sx});
            write_reg(CFG_SOURCE_Y, {16'h0, sy});
            write_reg(CFG_SOURCE_Z, {16'h0, sz});
            write_reg(CFG_MOMENT_ROW0, rand_row());
            write_reg(CFG_MOMENT_ROW1, rand_row());
            write_reg(CFG_MOMENT_ROW2, rand_row());
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_point(sx, sy, sz, 1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 4) == 0)
                    send_point(sx + $urandom_range(0, 64) - 32, sy + $urandom_range(0, 64) - 32,
                               sz + $urandom_range(0, 64) - 32, 1'($urandom_range(0, 1)));
                else
                    send_point(rand_coord(), rand_coord(), rand_coord(),
                               1'($urandom_range(0, 1)));
            end
            drain();
        end

        if (errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/mtp_pkg.sv
rtl/mtp_normalize.sv
rtl/moment_tensor_polarization_core.sv
verif/tb_moment_tensor_polarization_core.sv
